[design/md4_hash_engine_macros.svh]
// Assertion macros shared by the MD4 engine RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef MD4_HASH_ENGINE_MACROS_SVH
`define MD4_HASH_ENGINE_MACROS_SVH

// Same-cycle implication, masked during reset.
`define MD4_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("md4 check failed");

// Next-cycle implication, masked during reset.
`define MD4_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("md4 check failed");

`endif

[design/md4_pkg.sv]
// MD4 engine package: transaction payload types, core control/status structs,
// algorithm constants and the per-step schedule functions. No dependencies.
package md4_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       last_item;
	} item_t;

	typedef struct packed {
		logic [63:0] digest_high;
		logic [63:0] digest_low;
	} digest_t;

	typedef struct packed {
		logic start;
		logic init;
	} core_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_stat_t;

	localparam logic [31:0] IV_A     = 32'h67452301;
	localparam logic [31:0] IV_B     = 32'hEFCDAB89;
	localparam logic [31:0] IV_C     = 32'h98BADCFE;
	localparam logic [31:0] IV_D     = 32'h10325476;
	localparam logic [31:0] K_R2     = 32'h5A827999;
	localparam logic [31:0] K_R3     = 32'h6ED9EBA1;
	localparam logic [7:0]  PAD_MARK = 8'h80;
	localparam logic [5:0]  LEN_POS  = 6'd56;
	localparam logic [5:0]  STEP_LAST = 6'd47;

	localparam logic [1:0] RND_1 = 2'd0;
	localparam logic [1:0] RND_2 = 2'd1;
	localparam logic [1:0] RND_3 = 2'd2;

	// Message word used by a given step (0..47).
	function automatic logic [3:0] md4_word_idx(input logic [5:0] step);
		logic [3:0] idx;
		case (step[5:4])
			RND_1: idx = step[3:0];
			RND_2: idx = {step[1:0], step[3:2]};
			RND_3: idx = {step[0], step[1], step[2], step[3]};
			default: idx = step[3:0];
		endcase
		return idx;
	endfunction

	// Left-rotate amount for a given step.
	function automatic logic [4:0] md4_rot(input logic [5:0] step);
		logic [4:0] s;
		case ({step[5:4], step[1:0]})
			{RND_1, 2'd0}: s = 5'd3;
			{RND_1, 2'd1}: s = 5'd7;
			{RND_1, 2'd2}: s = 5'd11;
			{RND_1, 2'd3}: s = 5'd19;
			{RND_2, 2'd0}: s = 5'd3;
			{RND_2, 2'd1}: s = 5'd5;
			{RND_2, 2'd2}: s = 5'd9;
			{RND_2, 2'd3}: s = 5'd13;
			{RND_3, 2'd0}: s = 5'd3;
			{RND_3, 2'd1}: s = 5'd9;
			{RND_3, 2'd2}: s = 5'd11;
			{RND_3, 2'd3}: s = 5'd15;
			default: s = 5'd3;
		endcase
		return s;
	endfunction

endpackage

[design/md4_core.sv]
// MD4 compression core: one shared step unit iterated over 48 steps, then
// the chaining-value add. Holds the chaining value. Depends on md4_pkg.
`include "md4_hash_engine_macros.svh"

module md4_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  md4_pkg::core_ctl_t     ctl,
	output logic [3:0]             word_idx,
	input  logic [31:0]            word,
	output logic [3:0][31:0]       chain,
	output md4_pkg::core_stat_t    stat
);
	import md4_pkg::*;

	typedef enum logic [1:0] {
		C_IDLE,
		C_STEP,
		C_ADD
	} core_state_t;

	core_state_t      state_q;
	logic [5:0]       step_q;
	logic [31:0]      a_q, b_q, c_q, d_q;
	logic [3:0][31:0] chain_q;
	logic             done_q;

	logic [31:0] f_val;
	logic [31:0] k_val;
	logic [31:0] sum;
	logic [4:0]  rot;
	logic [31:0] step_out;

	assign word_idx = md4_word_idx(step_q);
	assign rot      = md4_rot(step_q);

	always_comb begin
		case (step_q[5:4])
			RND_1: begin
				f_val = (b_q & c_q) | (~b_q & d_q);
				k_val = '0;
			end
			RND_2: begin
				f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
				k_val = K_R2;
			end
			default: begin
				f_val = b_q ^ c_q ^ d_q;
				k_val = K_R3;
			end
		endcase
	end

	assign sum      = a_q + f_val + word + k_val;
	// rot is never zero, so the right shift stays below 32
	assign step_out = (sum << rot) | (sum >> (6'd32 - {1'b0, rot}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
			chain_q <= {IV_D, IV_C, IV_B, IV_A};
			a_q     <= '0;
			b_q     <= '0;
			c_q     <= '0;
			d_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				C_IDLE: begin
					if (ctl.init) begin
						chain_q <= {IV_D, IV_C, IV_B, IV_A};
					end else if (ctl.start) begin
						a_q     <= chain_q[0];
						b_q     <= chain_q[1];
						c_q     <= chain_q[2];
						d_q     <= chain_q[3];
						step_q  <= '0;
						state_q <= C_STEP;
					end
				end
				C_STEP: begin
					// roles rotate a <- d, b <- new, c <- b, d <- c
					a_q <= d_q;
					b_q <= step_out;
					c_q <= b_q;
					d_q <= c_q;
					step_q <= step_q + 6'd1;
					if (step_q == STEP_LAST) begin
						state_q <= C_ADD;
					end
				end
				C_ADD: begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
					done_q  <= 1'b1;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign chain     = chain_q;
	assign stat.busy = (state_q != C_IDLE);
	assign stat.done = done_q;

	`MD4_ASSERT_NOW(a_start_idle, ctl.start, state_q == C_IDLE)
	`MD4_ASSERT_NEXT(a_done_pulse, done_q, !done_q)
	`MD4_ASSERT_NOW(a_step_range, state_q == C_STEP, step_q <= STEP_LAST)

endmodule

[design/md4_hash_engine.sv]
// MD4 hash engine top level: byte packing, padding sequencer, block store
// and digest output register. Depends on md4_pkg and md4_core.
`include "md4_hash_engine_macros.svh"

// Message bytes are taken one per transaction on the item channel, one per
// cycle while a block fills. Every 64th byte starts a compression of 48
// steps on a single shared step unit plus one chaining add, and item_ready
// stays low until that compression is done. The item with last_item set
// (with or without a byte) starts padding: one block word is written per
// cycle from the end of the message to word 15, followed by one
// compression, or two plus a second padding pass over the whole block when
// 56 or more bytes sit in the final block. The digest is then loaded into
// an output register, so a new message can start while the digest still
// waits for digest_ready.
module md4_hash_engine (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  md4_pkg::item_t   item,
	output logic             digest_valid,
	input  logic             digest_ready,
	output md4_pkg::digest_t digest
);
	import md4_pkg::*;

	typedef enum logic [1:0] {
		T_IDLE,
		T_COMP,
		T_PAD,
		T_FINAL
	} top_state_t;

	top_state_t state_q;
	logic [5:0]  fill_q;
	logic [63:0] byte_total_q;
	logic [3:0]  wi_q;
	logic        pad_q;
	logic        fin_q;
	logic        extra_q;
	logic        mark_done_q;
	logic        digest_valid_q;
	digest_t     digest_q;
	core_ctl_t   ctl_q;
	core_stat_t  stat;

	logic [31:0]      blk_q [16];
	logic [3:0]       word_idx;
	logic [3:0][31:0] chain;

	logic        accept;
	logic [5:0]  fill_nx;
	logic        blk_we;
	logic [3:0]  blk_wi;
	logic [3:0]  blk_be;
	logic [31:0] blk_wd;
	logic [5:0]  lane_pos;
	logic [63:0] len_bits;
	logic        len_word;
	logic        fin_load;

	assign item_ready = (state_q == T_IDLE);
	assign accept     = item_valid && item_ready;
	assign fill_nx    = item.byte_present ? fill_q + 6'd1 : fill_q;
	assign len_bits   = {byte_total_q[60:0], 3'b000};
	assign len_word   = !extra_q && (wi_q[3:1] == 3'b111);
	assign fin_load   = (state_q == T_FINAL) && (!digest_valid_q || digest_ready);

	md4_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl_q),
		.word_idx (word_idx),
		.word     (blk_q[word_idx]),
		.chain    (chain),
		.stat     (stat)
	);

	// write port: a byte lane when filling, lanes from the data end when padding
	always_comb begin
		blk_we   = 1'b0;
		blk_wi   = fill_q[5:2];
		blk_be   = '0;
		blk_wd   = '0;
		lane_pos = '0;
		if (accept && item.byte_present) begin
			blk_we = 1'b1;
			blk_be = 4'b0001 << fill_q[1:0];
			blk_wd = {4{item.data_byte}};
		end else if (state_q == T_PAD) begin
			blk_we = 1'b1;
			blk_wi = wi_q;
			if (len_word) begin
				blk_be = 4'b1111;
				blk_wd = wi_q[0] ? len_bits[63:32] : len_bits[31:0];
			end else begin
				for (int l = 0; l < 4; l++) begin
					lane_pos = {wi_q, 2'(l)};
					if (mark_done_q || lane_pos > fill_q) begin
						blk_be[l] = 1'b1;
					end else if (lane_pos == fill_q) begin
						blk_be[l] = 1'b1;
						blk_wd[8*l +: 8] = PAD_MARK;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (blk_we) begin
			for (int l = 0; l < 4; l++) begin
				if (blk_be[l]) begin
					blk_q[blk_wi][8*l +: 8] <= blk_wd[8*l +: 8];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= T_IDLE;
			fill_q         <= '0;
			byte_total_q   <= '0;
			wi_q           <= '0;
			pad_q          <= 1'b0;
			fin_q          <= 1'b0;
			extra_q        <= 1'b0;
			mark_done_q    <= 1'b0;
			digest_valid_q <= 1'b0;
			ctl_q          <= '0;
		end else begin
			ctl_q <= '0;
			if (digest_valid_q && digest_ready) begin
				digest_valid_q <= 1'b0;
			end
			case (state_q)
				T_IDLE: begin
					if (accept) begin
						if (item.byte_present) begin
							fill_q       <= fill_nx;
							byte_total_q <= byte_total_q + 64'd1;
						end
						if (item.byte_present && fill_q == 6'd63) begin
							ctl_q.start <= 1'b1;
							state_q     <= T_COMP;
							pad_q       <= item.last_item;
							fin_q       <= 1'b0;
							wi_q        <= '0;
							extra_q     <= 1'b0;
						end else if (item.last_item) begin
							state_q <= T_PAD;
							wi_q    <= fill_nx[5:2];
							extra_q <= (fill_nx >= LEN_POS);
						end
					end
				end
				T_COMP: begin
					if (stat.done) begin
						if (fin_q) begin
							state_q <= T_FINAL;
						end else if (pad_q) begin
							pad_q   <= 1'b0;
							state_q <= T_PAD;
						end else begin
							state_q <= T_IDLE;
						end
					end
				end
				T_PAD: begin
					if (wi_q == 4'd15) begin
						ctl_q.start <= 1'b1;
						state_q     <= T_COMP;
						if (extra_q) begin
							// length goes in a further all-zero block
							extra_q     <= 1'b0;
							mark_done_q <= 1'b1;
							pad_q       <= 1'b1;
							wi_q        <= '0;
						end else begin
							fin_q <= 1'b1;
						end
					end else begin
						wi_q <= wi_q + 4'd1;
					end
				end
				T_FINAL: begin
					if (fin_load) begin
						digest_valid_q <= 1'b1;
						ctl_q.init     <= 1'b1;
						fill_q         <= '0;
						byte_total_q   <= '0;
						mark_done_q    <= 1'b0;
						fin_q          <= 1'b0;
						state_q        <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			digest_q.digest_low  <= {chain[1], chain[0]};
			digest_q.digest_high <= {chain[3], chain[2]};
		end
	end

	assign digest_valid = digest_valid_q;
	assign digest       = digest_q;

	`MD4_ASSERT_NOW(a_start_core_free, ctl_q.start, !stat.busy)
	`MD4_ASSERT_NOW(a_block_wrap, state_q == T_COMP && stat.done && !pad_q && !fin_q, fill_q == 6'd0)
	`MD4_ASSERT_NEXT(a_final_loads, fin_load, digest_valid)

endmodule

[bench/testbench.sv]
// Self-checking bench for md4_hash_engine: byte-stream stimulus, MD4 digest prediction
// and an in-order digest scoreboard. Depends on md4_pkg and the engine RTL only.
`timescale 1ns / 1ps

module testbench;
	import md4_pkg::*;

	localparam logic [19:0] ROT_R1 = {5'd19, 5'd11, 5'd7, 5'd3};
	localparam logic [19:0] ROT_R2 = {5'd13, 5'd9, 5'd5, 5'd3};
	localparam logic [19:0] ROT_R3 = {5'd15, 5'd11, 5'd9, 5'd3};
	localparam int ITEM_TARGET = 1850;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    digest_valid;
	logic    digest_ready;
	digest_t digest;

	// predicted engine state
	logic [31:0] chain_st [4];
	logic [31:0] words_st [16];
	logic [63:0] count_st;
	int          fill_st;

	digest_t expected_digests [$];
	int      mismatches = 0;
	int      items_sent = 0;
	bit      calm = 1'b0;
	bit      noise = 1'b0;
	bit      hold_req = 1'b0;
	int      hold_left = 0;

	md4_hash_engine u_top (
		.clk,
		.arst_n,
		.item_valid,
		.item_ready,
		.item,
		.digest_valid,
		.digest_ready,
		.digest
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void md4_restart();
		chain_st[0] = IV_A;
		chain_st[1] = IV_B;
		chain_st[2] = IV_C;
		chain_st[3] = IV_D;
		for (int q = 0; q < 16; q++) words_st[q] = '0;
		count_st = '0;
		fill_st = 0;
	endfunction

	function automatic void md4_mix_block();
		logic [31:0] v [4];
		logic [31:0] y, z, w, f, k, t;
		int ia, s, j;
		for (int q = 0; q < 4; q++) v[q] = chain_st[q];
		for (int i = 0; i < 48; i++) begin
			// working word rotates a, d, c, b
			ia = (4 - (i % 4)) % 4;
			y = v[(ia + 1) % 4];
			z = v[(ia + 2) % 4];
			w = v[(ia + 3) % 4];
			j = i % 16;
			if (i < 16) begin
				f = (y & z) | (~y & w);
				k = words_st[j];
				s = int'(ROT_R1[(i % 4) * 5 +: 5]);
			end else if (i < 32) begin
				f = (y & z) | (y & w) | (z & w);
				k = words_st[(j % 4) * 4 + j / 4] + K_R2;
				s = int'(ROT_R2[(i % 4) * 5 +: 5]);
			end else begin
				f = y ^ z ^ w;
				k = words_st[{j[0], j[1], j[2], j[3]}] + K_R3;
				s = int'(ROT_R3[(i % 4) * 5 +: 5]);
			end
			t = v[ia] + f + k;
			v[ia] = (t << s) | (t >> (32 - s));
		end
		for (int q = 0; q < 4; q++) chain_st[q] = chain_st[q] + v[q];
	endfunction

	// Advances the predicted state by one accepted transaction; queues a digest on last_item.
	function automatic void md4_absorb(input item_t it);
		digest_t d;
		logic [63:0] nbits;
		int pos;
		if (it.byte_present) begin
			words_st[fill_st / 4][(fill_st % 4) * 8 +: 8] = it.data_byte;
			count_st = count_st + 64'd1;
			fill_st = (fill_st + 1) % 64;
			if (fill_st == 0) md4_mix_block();
		end
		if (!it.last_item) return;
		pos = fill_st;
		words_st[pos / 4][(pos % 4) * 8 +: 8] = PAD_MARK;
		pos++;
		if (pos > int'(LEN_POS)) begin
			while (pos < 64) begin
				words_st[pos / 4][(pos % 4) * 8 +: 8] = 8'h00;
				pos++;
			end
			md4_mix_block();
			pos = 0;
		end
		while (pos < int'(LEN_POS)) begin
			words_st[pos / 4][(pos % 4) * 8 +: 8] = 8'h00;
			pos++;
		end
		nbits = count_st << 3;
		words_st[14] = nbits[31:0];
		words_st[15] = nbits[63:32];
		md4_mix_block();
		d.digest_low = {chain_st[1], chain_st[0]};
		d.digest_high = {chain_st[3], chain_st[2]};
		expected_digests.push_back(d);
		md4_restart();
	endfunction

	task automatic push_item(input logic [7:0] b, input logic p, input logic l);
		item_t nxt;
		nxt.data_byte = b;
		nxt.byte_present = p;
		nxt.last_item = l;
		if (!calm && $urandom_range(99) < 9) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(5, 1)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= nxt;
		do @(posedge clk); while (!item_ready);
		md4_absorb(nxt);
		if (p || l) items_sent++;
	endtask

	// len message bytes; the final byte rides on the last_item transaction when asked
	task automatic send_message(input int len, input bit tail_on_last);
		int n;
		for (n = 0; n < len; n++) begin
			if (noise && $urandom_range(99) < 4) push_item(8'($urandom_range(255)), 1'b0, 1'b0);
			push_item(8'($urandom_range(255)), 1'b1, tail_on_last && (n == len - 1));
		end
		if (!tail_on_last || len == 0) push_item(8'($urandom_range(255)), 1'b0, 1'b1);
	endtask

	task automatic test_corner_items();
		push_item(8'h00, 1'b0, 1'b1);      // empty message
		push_item(8'hFF, 1'b0, 1'b0);      // no byte, no end: ignored
		push_item(8'hA5, 1'b0, 1'b1);
		push_item(8'h00, 1'b1, 1'b1);      // single byte carried on the end
		push_item(8'hFF, 1'b1, 1'b0);
		push_item(8'h00, 1'b0, 1'b1);
		push_item(8'h61, 1'b1, 1'b0);
		push_item(8'h62, 1'b1, 1'b0);
		push_item(8'h63, 1'b1, 1'b1);
		push_item(8'h5A, 1'b1, 1'b0);
		push_item(8'h00, 1'b0, 1'b0);      // gap transaction inside a message
		push_item(8'hC3, 1'b1, 1'b1);
		push_item(8'hFF, 1'b0, 1'b1);
		push_item(8'h00, 1'b0, 1'b1);
	endtask

	// Lengths around the 56-byte length-field cutoff and the block edges.
	task automatic test_padding_boundaries();
		int sizes [10];
		sizes = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
		for (int q = 0; q < 10; q++) send_message(sizes[q], 1'(q % 2));
	endtask

	// Output stalled long enough that the digest register and then the input stall.
	task automatic test_output_backpressure();
		hold_req = 1'b1;
		for (int q = 0; q < 10; q++) send_message($urandom_range(5), 1'($urandom_range(1)));
	endtask

	task automatic test_random_messages();
		int pick, len;
		noise = 1'b1;
		while (items_sent < ITEM_TARGET) begin
			calm = (items_sent >= 1150 && items_sent < 1450);
			pick = $urandom_range(99);
			if (pick < 55) len = $urandom_range(20);
			else if (pick < 85) len = $urandom_range(72, 48);
			else len = $urandom_range(140, 100);
			send_message(len, 1'($urandom_range(1)));
		end
		calm = 1'b0;
		noise = 1'b0;
	endtask

	initial begin : digest_sink
		digest_t want;
		digest_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (digest_valid && digest_ready) begin
				if (expected_digests.size() == 0) begin
					mismatches++;
					$display("%0t: digest with none expected, got %h", $time, digest);
				end else begin
					want = expected_digests.pop_front();
					if (digest.digest_low !== want.digest_low) begin
						mismatches++;
						$display("%0t: digest_low expected %h got %h", $time,
							want.digest_low, digest.digest_low);
					end
					if (digest.digest_high !== want.digest_high) begin
						mismatches++;
						$display("%0t: digest_high expected %h got %h", $time,
							want.digest_high, digest.digest_high);
					end
				end
			end
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 600;
			end
			if (hold_left > 0) begin
				hold_left--;
				digest_ready <= 1'b0;
			end else begin
				digest_ready <= calm || ($urandom_range(99) >= 9);
			end
		end
	end

	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		md4_restart();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_items();
		test_padding_boundaries();
		test_output_backpressure();
		test_random_messages();
		item_valid <= 1'b0;
		while (expected_digests.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
